// File: sv/itad_pkg.sv
// itad_pkg: shared constants and types for the interval formatter
// no dependencies
`timescale 1ns / 1ps
package itad_pkg;
    localparam int DAY_DIGITS_DEF = 10;
    localparam int SECS_W = 50;
    localparam int NANOS_W = 32;
    localparam int CHAR_W = 8;
    localparam int NANO_DIGITS = 9;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT = 8'h2e;

    // digit cells of the conversion chain
    localparam int DIGIT_W = 5;
    localparam int RAD_DEC = 10;
    localparam int RAD_SIX = 6;
    localparam int RAD_HOUR = 24;
    // two input bits enter the chain per step
    localparam int CONV_STEPS = SECS_W / 2;
    localparam int NS_STEPS = NANOS_W / 2;

    // one character slot of the output row
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } slot_t;
endpackage

// File: sv/itad_cell.sv
// itad_cell: one slot of the output shift row
// depends on itad_pkg
`timescale 1ns / 1ps
module itad_cell (
    input  logic                  clk,
    input  logic                  load,
    input  logic                  shift,
    input  itad_pkg::slot_t       load_slot,
    input  itad_pkg::slot_t       from_right,
    output itad_pkg::slot_t       slot
);
    import itad_pkg::*;

    slot_t slot_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= load_slot;
        else if (shift)
            slot_reg <= from_right;
    end

    assign slot = slot_reg;
endmodule

// File: sv/itad_digits.sv
// itad_digits: one mixed-radix digit cell of the binary to decimal chain
// doubles its digit twice per step, taking two carries from the cell below; depends on itad_pkg
`timescale 1ns / 1ps
module itad_digits #(
    parameter int RADIX = itad_pkg::RAD_DEC
) (
    input  logic                         clk,
    input  logic                         clear,
    input  logic                         step,
    input  logic                         cin_a,
    input  logic                         cin_b,
    output logic                         cout_a,
    output logic                         cout_b,
    output logic [itad_pkg::DIGIT_W-1:0] digit
);
    import itad_pkg::*;

    localparam logic [DIGIT_W-1:0] HALF = DIGIT_W'(RADIX / 2);
    localparam logic [DIGIT_W:0]   RAD  = (DIGIT_W + 1)'(RADIX);

    logic [DIGIT_W-1:0] dig_reg, mid, dig_next;
    logic [DIGIT_W:0]   dbl_a, dbl_b;

    // with an even radix the carry out of a doubling depends only on the digit itself
    assign cout_a   = (dig_reg >= HALF);
    assign dbl_a    = {dig_reg, cin_a};
    assign mid      = DIGIT_W'(dbl_a - (cout_a ? RAD : '0));
    assign cout_b   = (mid >= HALF);
    assign dbl_b    = {mid, cin_b};
    assign dig_next = DIGIT_W'(dbl_b - (cout_b ? RAD : '0));

    always_ff @(posedge clk)
    begin
        if (clear)
            dig_reg <= '0;
        else if (step)
            dig_reg <= dig_next;
    end

    assign digit = dig_reg;
endmodule

// File: sv/interval_to_ascii_dhms_top.sv
// interval_to_ascii_dhms_top: seconds/nanos to "D..D hh:mm:ss.nnnnnnnnn" as a beat stream
// depends on itad_pkg, itad_cell, itad_digits
// each input beat goes through 25 two-bit conversion steps, then the result is loaded into the row
// the row presents DAY_DIGITS + 19 characters per item, one character per cycle unless out_stall
// next item taken as the previous result moves into the row; no gap if DAY_DIGITS >= 7
// reset clears the control flags and counters; digit cells, data and row registers are not reset
`timescale 1ns / 1ps
module interval_to_ascii_dhms_top #(
    parameter int DAY_DIGITS = itad_pkg::DAY_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [itad_pkg::SECS_W-1:0]   total_seconds,
    input  logic signed [itad_pkg::NANOS_W-1:0] nanos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itad_pkg::CHAR_W-1:0]   char_code,
    output logic                          last
);
    import itad_pkg::*;

    localparam int NCH = DAY_DIGITS + 19;
    localparam int CW = $clog2(NCH + 1);
    // time chain from the bottom: sec ones, sec tens, min ones, min tens, hours, day digits
    localparam int NT = DAY_DIGITS + 5;
    localparam int NN = NANO_DIGITS;
    localparam int KW = $clog2(CONV_STEPS + 1);

    // converter
    logic [SECS_W-1:0]  sec_sh_reg;
    logic [NANOS_W-1:0] ns_sh_reg;
    logic [KW-1:0]      step_cnt_reg;
    logic               conv_busy_reg, conv_done_reg;
    logic               ovf_reg;
    logic               in_take, conv_step, ns_step, conv_end;
    logic [NANOS_W-1:0] nmag;
    logic [DIGIT_W-1:0] tdig [NT];
    logic               tca [NT+1];
    logic               tcb [NT+1];
    logic [DIGIT_W-1:0] ndig [NN];
    logic               nca [NN+1];
    logic               ncb [NN+1];
    logic [DIGIT_W-1:0] hour, h_tens, h_ones;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_v_reg;
    logic            row_busy, row_load, row_shift;

    // row takes the converted item when idle or as its last character is taken
    assign row_shift = out_v_reg && !out_stall;
    assign row_busy = out_v_reg && !(row_shift && cnt_reg == CW'(1));
    assign row_load = conv_done_reg && !row_busy;
    assign in_stall = conv_busy_reg || (conv_done_reg && !row_load);
    assign in_take = in_valid && !in_stall;

    assign conv_step = conv_busy_reg;
    // nanosecond bits enter in the last steps so leading zeros come first
    assign ns_step = conv_busy_reg && (step_cnt_reg <= KW'(NS_STEPS));
    assign conv_end = conv_busy_reg && (step_cnt_reg == KW'(1));

    assign nmag = nanos[NANOS_W-1] ? $unsigned(-nanos) : $unsigned(nanos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg <= 1'b0;
            conv_done_reg <= 1'b0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            if (in_take)
            begin
                conv_busy_reg <= 1'b1;
                step_cnt_reg  <= KW'(CONV_STEPS);
            end
            else if (conv_busy_reg)
            begin
                step_cnt_reg <= step_cnt_reg - KW'(1);
                if (conv_end)
                    conv_busy_reg <= 1'b0;
            end
            if (conv_end)
                conv_done_reg <= 1'b1;
            else if (row_load)
                conv_done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sec_sh_reg <= total_seconds;
            ns_sh_reg  <= nmag;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            if (conv_step)
            begin
                sec_sh_reg <= {sec_sh_reg[SECS_W-3:0], 2'b00};
                // a carry out of the top day digit means too many days
                if (tca[NT] || tcb[NT])
                    ovf_reg <= 1'b1;
            end
            if (ns_step)
                ns_sh_reg <= {ns_sh_reg[NANOS_W-3:0], 2'b00};
        end
    end

    assign tca[0] = sec_sh_reg[SECS_W-1];
    assign tcb[0] = sec_sh_reg[SECS_W-2];
    assign nca[0] = ns_sh_reg[NANOS_W-1];
    assign ncb[0] = ns_sh_reg[NANOS_W-2];

    genvar g;
    generate
        for (g = 0; g < NT; g++)
        begin : g_tchain
            localparam int R = (g == 4) ? RAD_HOUR :
                               (g == 1 || g == 3) ? RAD_SIX : RAD_DEC;
            itad_digits #(.RADIX(R)) u_dig (
                .clk    (clk),
                .clear  (in_take),
                .step   (conv_step),
                .cin_a  (tca[g]),
                .cin_b  (tcb[g]),
                .cout_a (tca[g+1]),
                .cout_b (tcb[g+1]),
                .digit  (tdig[g])
            );
        end
        // carry out of the top nanosecond digit is dropped: modulo one billion
        for (g = 0; g < NN; g++)
        begin : g_nchain
            itad_digits #(.RADIX(RAD_DEC)) u_dig (
                .clk    (clk),
                .clear  (in_take),
                .step   (ns_step),
                .cin_a  (nca[g]),
                .cin_b  (ncb[g]),
                .cout_a (nca[g+1]),
                .cout_b (ncb[g+1]),
                .digit  (ndig[g])
            );
        end
    endgenerate

    // hours split into two decimal digits, forced to 23 on overflow
    assign hour   = ovf_reg ? DIGIT_W'(23) : tdig[4];
    assign h_tens = (hour >= DIGIT_W'(20)) ? DIGIT_W'(2) :
                    (hour >= DIGIT_W'(10)) ? DIGIT_W'(1) : DIGIT_W'(0);
    assign h_ones = (hour >= DIGIT_W'(20)) ? hour - DIGIT_W'(20) :
                    (hour >= DIGIT_W'(10)) ? hour - DIGIT_W'(10) : hour;

    // build load image of the row
    slot_t load_s [NCH];
    slot_t cur_s  [NCH+1];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            load_s[i].last = (i == NCH - 1);
            load_s[i].ch = CH_ZERO;
        end
        for (int i = 0; i < DAY_DIGITS; i++)
            load_s[i].ch = ovf_reg ? CH_NINE : CH_ZERO + 8'(tdig[NT - 1 - i]);
        load_s[DAY_DIGITS].ch      = CH_SPACE;
        load_s[DAY_DIGITS + 1].ch  = CH_ZERO + 8'(h_tens);
        load_s[DAY_DIGITS + 2].ch  = CH_ZERO + 8'(h_ones);
        load_s[DAY_DIGITS + 3].ch  = CH_COLON;
        load_s[DAY_DIGITS + 4].ch  = ovf_reg ? CH_FIVE : CH_ZERO + 8'(tdig[3]);
        load_s[DAY_DIGITS + 5].ch  = ovf_reg ? CH_NINE : CH_ZERO + 8'(tdig[2]);
        load_s[DAY_DIGITS + 6].ch  = CH_COLON;
        load_s[DAY_DIGITS + 7].ch  = ovf_reg ? CH_FIVE : CH_ZERO + 8'(tdig[1]);
        load_s[DAY_DIGITS + 8].ch  = ovf_reg ? CH_NINE : CH_ZERO + 8'(tdig[0]);
        load_s[DAY_DIGITS + 9].ch  = CH_DOT;
        for (int i = 0; i < NN; i++)
            load_s[DAY_DIGITS + 10 + i].ch = CH_ZERO + 8'(ndig[NN - 1 - i]);
    end

    assign cur_s[NCH] = '0;

    generate
        for (g = 0; g < NCH; g++)
        begin : g_row
            itad_cell u_cell (
                .clk        (clk),
                .load       (row_load),
                .shift      (row_shift),
                .load_slot  (load_s[g]),
                .from_right (cur_s[g+1]),
                .slot       (cur_s[g])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (row_load)
            cnt_next = CW'(NCH);
        else if (row_shift)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            out_v_reg <= (cnt_next != '0);
        end
    end

    assign out_valid = out_v_reg;
    assign char_code = cur_s[0].ch;
    assign last      = cur_s[0].last;

    a_last_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (cnt_reg == CW'(1))))
        else $error("last flag out of step with count");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NCH))
        else $error("count beyond row length");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        row_load |-> (!out_v_reg || (row_shift && cnt_reg == CW'(1))))
        else $error("row loaded while busy");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        conv_busy_reg |-> in_stall)
        else $error("input beat taken while converting");
endmodule
